// File: design/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared constants for the predecoded block cache: defaults, operation and
// status codes, and the hash multiplier.
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int TABLE_BITS_DEF  = 10;
  localparam int ARENA_DEPTH_DEF = 4096;
  localparam int PROBES_DEF      = 8;

  localparam logic [31:0] KNUTH_MUL = 32'd2654435761;

  localparam logic [2:0] FUNC_LOOKUP = 3'd0;
  localparam logic [2:0] FUNC_RECORD = 3'd1;
  localparam logic [2:0] FUNC_CLOSE  = 3'd2;
  localparam logic [2:0] FUNC_CUT    = 3'd3;
  localparam logic [2:0] FUNC_READ   = 3'd4;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_FLUSHED = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_LOST    = 2'd3;

endpackage

// File: design/pbc_hash.sv
// ----------------------------------------------------------------------------
// pbc_hash
// Registered multiplicative hash: top TABLE_BITS bits of (pc >> 1) * K.
// ----------------------------------------------------------------------------
module pbc_hash #(
  parameter int TABLE_BITS = pbc_pkg::TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic [31:0]           pc,
  output logic [TABLE_BITS-1:0] hash
);
  import pbc_pkg::*;

  logic [31:0] product;

  assign product = {1'b0, pc[31:1]} * KNUTH_MUL;

  always_ff @(posedge clk) begin
    hash <= product[31 -: TABLE_BITS];
  end

endmodule

// File: design/predecoded_block_cache.sv
// ----------------------------------------------------------------------------
// predecoded_block_cache
// Cache of predecoded instruction runs keyed by (pc, variant).
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one operation per transaction:
// lookup, record entry, close block, cut recording or read entry. Output
// channel (out_valid / out_stall) returns one result per operation.
// One operation is in flight at a time; in_stall is low only when idle.
// Lookup, and close of a recording that holds entries, run execute, hash,
// slot read, then probe 1 to PROBES slots, one synchronous slot table read
// per cycle. Record and read entry add an arena write or read state; cut,
// other closes and unused codes go from execute straight to completion.
// The next transaction is taken from the cycle the result is raised.
// A record that must flush first sweeps the slot table (1024 slots by
// default), one slot a cycle. After reset the same sweep runs, with
// in_stall high, before the first transaction is taken.
// A result held by out_stall stays in the output register; the next
// transaction may be taken meanwhile and waits for the register to free.
// ----------------------------------------------------------------------------
module predecoded_block_cache #(
  parameter int TABLE_BITS  = pbc_pkg::TABLE_BITS_DEF,
  parameter int ARENA_DEPTH = pbc_pkg::ARENA_DEPTH_DEF,
  parameter int PROBES      = pbc_pkg::PROBES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [31:0] pc,
  input  logic [3:0]  variant,
  input  logic [15:0] opcode,
  input  logic [15:0] handler,
  input  logic [11:0] entry_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [11:0] block_start,
  output logic [12:0] block_length,
  output logic [15:0] entry_handler,
  output logic [15:0] entry_opcode,
  output logic [1:0]  status
);
  import pbc_pkg::*;

  localparam int AW    = $clog2(ARENA_DEPTH);
  localparam int PW    = $clog2(PROBES + 1);
  localparam int SLOTS = 1 << TABLE_BITS;
  localparam logic [AW+1:0] DEPTH_W = (AW+2)'(ARENA_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_PRB   = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_REC   = 4'd5;
  localparam logic [3:0] S_ARD   = 4'd6;
  localparam logic [3:0] S_CLEAR = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  typedef struct packed {
    logic [31:0] pc;
    logic [3:0]  var_tag;
    logic [AW-1:0] start;
    logic [AW:0]   len;
  } slot_t;

  logic [3:0] state;

  // latched transaction
  logic [2:0]  op;
  logic [31:0] op_pc;
  logic [3:0]  op_var;
  logic [15:0] op_opc;
  logic [15:0] op_hnd;
  logic [11:0] op_idx;

  logic [31:0] key_pc;
  logic [3:0]  key_var;
  logic [TABLE_BITS-1:0] hash_q;
  logic [PW-1:0] probe_i;
  logic [TABLE_BITS-1:0] clr_idx;
  logic clr_rec;

  logic [AW:0] arena_used;
  logic        recording;
  logic [31:0] rec_pc;
  logic [3:0]  rec_variant;
  logic [AW:0] rec_count;

  // working result
  logic          res_found;
  logic [AW-1:0] res_start;
  logic [AW:0]   res_len;
  logic [15:0]   res_hnd;
  logic [15:0]   res_opc;
  logic [1:0]    res_status;

  // memories
  slot_t tbl [SLOTS];
  slot_t tbl_q;
  logic  tbl_re, tbl_we;
  logic [TABLE_BITS-1:0] tbl_ra, tbl_wa;
  slot_t tbl_wd;

  logic [31:0] arena [ARENA_DEPTH];
  logic [31:0] arena_q;
  logic        arena_we, arena_re;
  logic [AW-1:0] arena_ra;

  logic chk_empty, chk_match, chk_stop, chk_last;
  logic flush_need;
  logic [TABLE_BITS-1:0] probe_addr;
  logic [31:0] idx_w, start_w, len_w;
  logic [AW-1:0] start_calc;

  pbc_hash #(.TABLE_BITS(TABLE_BITS)) u_hash (
    .clk  (clk),
    .pc   (key_pc),
    .hash (hash_q)
  );

  assign in_stall = (state != S_IDLE);

  always_comb begin
    chk_empty  = (tbl_q.len == '0);
    chk_match  = (tbl_q.pc == key_pc) && (tbl_q.var_tag == key_var);
    chk_stop   = chk_empty || chk_match;
    chk_last   = (probe_i == PW'(PROBES - 1));
    probe_addr = TABLE_BITS'(32'(hash_q) + 32'(probe_i));
    start_calc = (rec_count <= arena_used) ? AW'(arena_used - rec_count) : '0;
    flush_need = !recording && ({1'b0, arena_used} + 1'b1 >= DEPTH_W);

    tbl_re = (state == S_PRB) || ((state == S_CHK) && !chk_stop && !chk_last);
    tbl_ra = (state == S_PRB) ? hash_q : TABLE_BITS'(32'(probe_addr) + 32'd1);
    tbl_we = (state == S_CLEAR) || ((state == S_CHK) && (op == FUNC_CLOSE) && chk_stop);
    tbl_wa = (state == S_CLEAR) ? clr_idx : probe_addr;
    tbl_wd = (state == S_CLEAR) ? '0 : slot_t'{key_pc, key_var, start_calc, rec_count};

    idx_w    = 32'(op_idx);
    arena_re = (state == S_EXEC) && (op == FUNC_READ);
    arena_ra = idx_w[AW-1:0];
    arena_we = (state == S_REC) && (32'(arena_used) < ARENA_DEPTH);

    start_w = 32'(res_start);
    len_w   = 32'(res_len);
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl[tbl_wa] <= tbl_wd;
    if (tbl_re) tbl_q <= tbl[tbl_ra];
  end

  always_ff @(posedge clk) begin
    if (arena_we) arena[arena_used[AW-1:0]] <= {op_hnd, op_opc};
    if (arena_re) arena_q <= arena[arena_ra];
  end

  // payload of the latched transaction
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op     <= func;
      op_pc  <= pc;
      op_var <= variant;
      op_opc <= opcode;
      op_hnd <= handler;
      op_idx <= entry_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      clr_rec     <= 1'b0;
      arena_used  <= '0;
      recording   <= 1'b0;
      rec_pc      <= '0;
      rec_variant <= '0;
      rec_count   <= '0;
      probe_i     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          res_found  <= 1'b0;
          res_start  <= '0;
          res_len    <= '0;
          res_hnd    <= '0;
          res_opc    <= '0;
          res_status <= (op == FUNC_RECORD && flush_need) ? STATUS_FLUSHED : STATUS_DONE;
          probe_i    <= '0;
          case (op)
            FUNC_LOOKUP: begin
              key_pc  <= op_pc;
              key_var <= op_var;
              state   <= S_HASH;
            end
            FUNC_RECORD: begin
              if (flush_need) begin
                // flush: empty the table before recording
                arena_used <= '0;
                recording  <= 1'b0;
                clr_idx    <= '0;
                clr_rec    <= 1'b1;
                state      <= S_CLEAR;
              end else begin
                state <= S_REC;
              end
            end
            FUNC_CLOSE: begin
              recording <= 1'b0;
              if (recording && rec_count != '0) begin
                key_pc  <= rec_pc;
                key_var <= rec_variant;
                state   <= S_HASH;
              end else begin
                state <= S_DONE;
              end
            end
            FUNC_CUT: begin
              if (recording) begin
                arena_used <= (rec_count <= arena_used) ? arena_used - rec_count : '0;
                recording  <= 1'b0;
              end
              state <= S_DONE;
            end
            FUNC_READ: begin
              state <= S_ARD;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_HASH: state <= S_PRB;
        S_PRB:  state <= S_CHK;
        S_CHK: begin
          if (chk_stop) begin
            if (op == FUNC_LOOKUP && !chk_empty) begin
              res_found <= 1'b1;
              res_start <= tbl_q.start;
              res_len   <= tbl_q.len;
            end
            state <= S_DONE;
          end else if (chk_last) begin
            if (op == FUNC_CLOSE) res_status <= STATUS_LOST;
            state <= S_DONE;
          end else begin
            probe_i <= probe_i + 1'b1;
          end
        end
        S_REC: begin
          if (!recording) begin
            rec_pc      <= op_pc;
            rec_variant <= op_var;
          end
          if (32'(arena_used) >= ARENA_DEPTH) begin
            recording  <= 1'b0;
            res_status <= STATUS_FULL;
            if (!recording) rec_count <= '0;
          end else begin
            recording  <= 1'b1;
            arena_used <= arena_used + 1'b1;
            rec_count  <= recording ? rec_count + 1'b1 : (AW+1)'(1);
          end
          state <= S_DONE;
        end
        S_ARD: begin
          if (idx_w < ARENA_DEPTH) begin
            res_hnd <= arena_q[31:16];
            res_opc <= arena_q[15:0];
          end
          state <= S_DONE;
        end
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) begin
            clr_rec <= 1'b0;
            state   <= clr_rec ? S_REC : S_IDLE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // raise on completion, drop once the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      found         <= res_found;
      block_start   <= start_w[11:0];
      block_length  <= len_w[12:0];
      entry_handler <= res_hnd;
      entry_opcode  <= res_opc;
      status        <= res_status;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    32'(arena_used) <= ARENA_DEPTH)
    else $error("arena fill beyond depth");

  a_rec_count: assert property (@(posedge clk) disable iff (rst)
    recording |-> (rec_count <= arena_used))
    else $error("recording longer than arena fill");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside completion");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> (32'(probe_i) < PROBES))
    else $error("probe counter out of range");

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> !tbl_re)
    else $error("slot table read and write in one cycle");

endmodule

// File: verif/tb_predecoded_block_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_predecoded_block_cache
// Self-checking bench for the predecoded block cache. Each operation is
// mirrored in a behavioural copy of the slot table and entry arena, and every
// result is compared field by field. Covers directed corner cases, probe
// collisions, arena exhaustion and flush, and random record/close sequences
// under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_predecoded_block_cache;
  import pbc_pkg::*;

  localparam int SLOTS  = 1 << TABLE_BITS_DEF;
  localparam int DEPTH  = ARENA_DEPTH_DEF;
  localparam int NPROBE = PROBES_DEF;

  typedef struct packed {
    logic        found;
    logic [11:0] start;
    logic [12:0] length;
    logic [15:0] ehandler;
    logic [15:0] eopcode;
    logic [1:0]  status;
  } cache_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  func = FUNC_LOOKUP;
  logic [31:0] pc = '0;
  logic [3:0]  variant = '0;
  logic [15:0] opcode = '0;
  logic [15:0] handler = '0;
  logic [11:0] entry_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic [11:0] block_start;
  logic [12:0] block_length;
  logic [15:0] entry_handler;
  logic [15:0] entry_opcode;
  logic [1:0]  status;

  predecoded_block_cache dut (.*);

  always #1 clk = ~clk;

  // behavioural copy of the cache
  logic [31:0] tbl_pc    [SLOTS];
  logic [3:0]  tbl_var   [SLOTS];
  int          tbl_start [SLOTS];
  int          tbl_len   [SLOTS];
  logic [15:0] arena_hnd [DEPTH];
  logic [15:0] arena_opc [DEPTH];
  int          arena_fill;
  int          written_top;
  bit          rec_open;
  logic [31:0] rec_key_pc;
  logic [3:0]  rec_key_var;
  int          rec_len;

  cache_result_t pending_results[$];
  int  mismatches = 0;
  bit  failed = 1'b0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  logic [31:0] pc_pool[24];

  function automatic int slot_of(logic [31:0] p);
    logic [31:0] h;
    h = (p >> 1) * KNUTH_MUL;
    return int'(h[31:32-TABLE_BITS_DEF]);
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < SLOTS; i++) tbl_len[i] = 0;
    arena_fill = 0;
    rec_open = 1'b0;
  endfunction

  function automatic cache_result_t predict_cache(logic [2:0] f, logic [31:0] p,
      logic [3:0] v, logic [15:0] o, logic [15:0] hd, logic [11:0] idx);
    cache_result_t r;
    int k, s;
    bit stored;
    r = '0;
    k = slot_of(p);
    case (f)
      FUNC_LOOKUP: begin
        for (int i = 0; i < NPROBE; i++) begin
          s = (k + i) % SLOTS;
          if (tbl_len[s] == 0) break;
          if (tbl_pc[s] == p && tbl_var[s] == v) begin
            r.found = 1'b1;
            r.start = tbl_start[s][11:0];
            r.length = tbl_len[s][12:0];
            break;
          end
        end
      end
      FUNC_RECORD: begin
        if (!rec_open) begin
          if (arena_fill + 1 >= DEPTH) begin
            wipe_table();
            r.status = STATUS_FLUSHED;
          end
          rec_key_pc = p;
          rec_key_var = v;
          rec_len = 0;
          rec_open = 1'b1;
        end
        if (arena_fill >= DEPTH) begin
          rec_open = 1'b0;
          r.status = STATUS_FULL;
        end else begin
          arena_hnd[arena_fill] = hd;
          arena_opc[arena_fill] = o;
          arena_fill++;
          rec_len++;
          if (arena_fill > written_top) written_top = arena_fill;
        end
      end
      FUNC_CLOSE: begin
        if (rec_open && rec_len != 0) begin
          stored = 1'b0;
          k = slot_of(rec_key_pc);
          for (int i = 0; i < NPROBE; i++) begin
            s = (k + i) % SLOTS;
            if (tbl_len[s] != 0 && (tbl_pc[s] != rec_key_pc || tbl_var[s] != rec_key_var))
              continue;
            tbl_pc[s] = rec_key_pc;
            tbl_var[s] = rec_key_var;
            tbl_start[s] = (rec_len <= arena_fill) ? arena_fill - rec_len : 0;
            tbl_len[s] = rec_len;
            stored = 1'b1;
            break;
          end
          if (!stored) r.status = STATUS_LOST;
        end
        rec_open = 1'b0;
      end
      FUNC_CUT: begin
        if (rec_open) begin
          arena_fill = (rec_len <= arena_fill) ? arena_fill - rec_len : 0;
          rec_open = 1'b0;
        end
      end
      FUNC_READ: begin
        r.ehandler = arena_hnd[idx];
        r.eopcode = arena_opc[idx];
      end
      default: ;
    endcase
    return r;
  endfunction

  // one transaction on the input channel; fields settle at a rising edge
  task automatic send_op(logic [2:0] f, logic [31:0] p, logic [3:0] v,
      logic [15:0] o, logic [15:0] hd, logic [11:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    pc <= p;
    variant <= v;
    opcode <= o;
    handler <= hd;
    entry_index <= idx;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_cache(f, p, v, o, hd, idx));
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [11:0] written_index();
    return 12'($urandom_range(written_top - 1));
  endfunction

  task automatic test_directed();
    send_op(FUNC_LOOKUP, 32'h0, 4'h0, 16'h0, 16'h0, 12'h0);
    send_op(FUNC_CLOSE, 32'h0, 4'h0, 16'h0, 16'h0, 12'h0);
    send_op(FUNC_CUT, 32'h0, 4'h0, 16'h0, 16'h0, 12'h0);
    send_op(FUNC_RECORD, 32'h0, 4'h0, 16'h0000, 16'h0000, 12'h0);
    send_op(FUNC_RECORD, 32'hFFFF_FFFF, 4'hF, 16'hFFFF, 16'hFFFF, 12'hFFF);
    send_op(FUNC_CLOSE, 32'hFFFF_FFFF, 4'hF, 16'h0, 16'h0, 12'h0);
    send_op(FUNC_LOOKUP, 32'h0, 4'h0, 16'h0, 16'h0, 12'h0);
    send_op(FUNC_LOOKUP, 32'h0, 4'hF, 16'h0, 16'h0, 12'h0);
    send_op(FUNC_READ, 32'h0, 4'h0, 16'h0, 16'h0, 12'h0);
    send_op(FUNC_READ, 32'h0, 4'h0, 16'h0, 16'h0, 12'h1);
    // start a recording, then give it back
    send_op(FUNC_RECORD, 32'hFFFF_FFFF, 4'hF, 16'hA5A5, 16'h5A5A, 12'h0);
    send_op(FUNC_CUT, 32'h0, 4'h0, 16'h0, 16'h0, 12'h0);
    send_op(FUNC_RECORD, 32'hFFFF_FFFF, 4'hF, 16'h1234, 16'hFEDC, 12'h0);
    send_op(FUNC_CLOSE, 32'h0, 4'h0, 16'h0, 16'h0, 12'h0);
    send_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 4'hF, 16'h0, 16'h0, 12'h0);
    send_op(3'd5, 32'hFFFF_FFFF, 4'hF, 16'hFFFF, 16'hFFFF, 12'h0);
    send_op(3'd6, 32'h0, 4'h0, 16'h0, 16'h0, 12'h0);
    send_op(3'd7, 32'h1, 4'h1, 16'h1, 16'h1, 12'h1);
    drain_results();
  endtask

  // nine variants of one pc share a probe window; the ninth is lost
  task automatic test_probe_overflow();
    for (int v = 0; v < NPROBE + 1; v++) begin
      send_op(FUNC_RECORD, 32'h8000_0001, 4'(v), 16'($urandom), 16'($urandom), 12'h0);
      send_op(FUNC_CLOSE, 32'h0, 4'h0, 16'h0, 16'h0, 12'h0);
    end
    for (int v = 0; v < NPROBE + 1; v++)
      send_op(FUNC_LOOKUP, 32'h8000_0001, 4'(v), 16'h0, 16'h0, 12'h0);
    drain_results();
  endtask

  // fill the arena in one recording, overrun it, then force a flush
  task automatic test_arena_exhaustion();
    send_op(FUNC_CUT, 32'h0, 4'h0, 16'h0, 16'h0, 12'h0);
    send_op(FUNC_RECORD, 32'h0000_4000, 4'h3, 16'($urandom), 16'($urandom), 12'h0);
    while (arena_fill < DEPTH)
      send_op(FUNC_RECORD, 32'h0, 4'h0, 16'($urandom), 16'($urandom), 12'h0);
    send_op(FUNC_RECORD, 32'h0, 4'h0, 16'hFFFF, 16'hFFFF, 12'h0);
    send_op(FUNC_CLOSE, 32'h0, 4'h0, 16'h0, 16'h0, 12'h0);
    send_op(FUNC_READ, 32'h0, 4'h0, 16'h0, 16'h0, 12'hFFF);
    send_op(FUNC_RECORD, 32'h0000_5000, 4'h1, 16'h0F0F, 16'hF0F0, 12'h0);
    send_op(FUNC_CLOSE, 32'h0, 4'h0, 16'h0, 16'h0, 12'h0);
    send_op(FUNC_LOOKUP, 32'h8000_0001, 4'h0, 16'h0, 16'h0, 12'h0);
    send_op(FUNC_LOOKUP, 32'h0000_5000, 4'h1, 16'h0, 16'h0, 12'h0);
    drain_results();
  endtask

  // mostly record runs closed under pooled keys, with lookups, reads and noise
  task automatic test_random_traffic(int n_items);
    int sent, kind, run;
    logic [31:0] p;
    logic [3:0] v;
    logic [2:0] f_noise;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      p = pc_pool[$urandom_range(23)];
      v = 4'($urandom_range(3));
      if (kind < 45) begin
        run = $urandom_range(1, 12);
        for (int i = 0; i < run; i++)
          send_op(FUNC_RECORD, (i == 0) ? p : 32'($urandom), (i == 0) ? v : 4'($urandom),
                  16'($urandom), 16'($urandom), 12'($urandom));
        send_op(($urandom_range(9) < 8) ? FUNC_CLOSE : FUNC_CUT, 32'($urandom),
                4'($urandom), 16'($urandom), 16'($urandom), 12'($urandom));
        sent += run + 1;
      end else if (kind < 75) begin
        send_op(FUNC_LOOKUP, p, v, 16'($urandom), 16'($urandom), 12'($urandom));
        sent++;
      end else if (kind < 88) begin
        if (written_top > 0)
          send_op(FUNC_READ, 32'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                  written_index());
        sent++;
      end else if (kind < 96) begin
        send_op(FUNC_LOOKUP, 32'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                12'($urandom));
        sent++;
      end else begin
        // keep random reads out of the noise: their index may be unwritten
        f_noise = 3'($urandom_range(2, 7));
        if (f_noise == FUNC_READ) f_noise = FUNC_CUT;
        send_op(f_noise, 32'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                12'($urandom));
        sent++;
      end
    end
    drain_results();
  endtask

  // receiver side: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cache_result_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got = '{found, block_start, block_length, entry_handler, entry_opcode, status};
      if (pending_results.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    wipe_table();
    written_top = 0;
    rec_key_pc = '0;
    rec_key_var = '0;
    rec_len = 0;
    for (int i = 0; i < DEPTH; i++) begin
      arena_hnd[i] = '0;
      arena_opc[i] = '0;
    end
    for (int i = 0; i < 24; i++) pc_pool[i] = $urandom;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_probe_overflow();
    test_arena_exhaustion();

    send_idle_pct = 24;
    stall_pct = 81;
    test_random_traffic(600);
    send_idle_pct = 81;
    stall_pct = 24;
    test_random_traffic(600);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    test_random_traffic(650);

    if (!failed && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
